@@ src/mmf9_pkg.sv @@
// shared types and constants for the magnitude median filter
// no dependencies; imported by the filter top level and its checker
package mmf9_pkg;

  // handshake state of one pipeline stage
  typedef struct packed {
    logic valid;
    logic take;
  } mmf9_stage_t;

  // accept edge to first output edge, in clock cycles
  localparam int unsigned MMF9_LATENCY = 2;

endpackage

@@ src/magnitude_median_filter_9.sv @@
// Sliding-window median filter ranked by magnitude. Every accepted word
// shifts one signed sample into a window of the last WINDOW_SIZE samples
// (zeros after reset, and those zeros count), and one result word follows:
// the window sample of middle rank, WINDOW_SIZE/2 counting from 0, when the
// window is ordered by descending magnitude with the positive value first
// on a tie. One word is accepted per clock cycle while the result side is
// not stalled; each word passes the window register, then the result
// register, which holds its result word while the output stalls.
// The rate is set by the combinational rank logic between the two: every
// sample is compared with every other in parallel, each sample's rank is
// counted and the one of middle rank is selected.
// Depends on mmf9_pkg.
module magnitude_median_filter_9
  import mmf9_pkg::*;
#(
  parameter int WINDOW_SIZE  = 9,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_median_out
);

  localparam int RANK_W = $clog2(WINDOW_SIZE);
  localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW_SIZE / 2);

  logic signed [SAMPLE_WIDTH-1:0] window_r [WINDOW_SIZE];
  logic        [SAMPLE_WIDTH-1:0] mag      [WINDOW_SIZE];
  logic        [RANK_W-1:0]       rank_cnt [WINDOW_SIZE];
  logic signed [SAMPLE_WIDTH-1:0] median_nxt;
  logic signed [SAMPLE_WIDTH-1:0] median_r;
  mmf9_stage_t                    win_st;
  mmf9_stage_t                    res_st;
  logic                           win_valid_r;
  logic                           res_valid_r;
  logic                           in_fire;

  // stage handshakes
  always_comb begin
    res_st.valid = res_valid_r;
    res_st.take  = !res_valid_r || out_ready;
    win_st.valid = win_valid_r;
    win_st.take  = !win_valid_r || res_st.take;
  end

  assign in_ready = win_st.take;
  assign in_fire  = in_valid && in_ready;

  // window shift line, oldest at entry 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        window_r[i] <= '0;
      end
    end else begin
      if (win_st.take) begin
        win_valid_r <= in_fire;
      end
      if (in_fire) begin
        for (int i = 0; i + 1 < WINDOW_SIZE; i++) begin
          window_r[i] <= window_r[i + 1];
        end
        window_r[WINDOW_SIZE - 1] <= in_sample_in;
      end
    end
  end

  // magnitudes; the most negative value maps to 2^(SAMPLE_WIDTH-1)
  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      mag[i] = window_r[i][SAMPLE_WIDTH-1] ?
               (SAMPLE_WIDTH'(~window_r[i]) + SAMPLE_WIDTH'(1)) :
               SAMPLE_WIDTH'(window_r[i]);
    end
  end

  // rank of each sample: how many others order ahead of it
  // equal values break the tie by position so every rank is taken once
  always_comb begin
    logic ahead;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      rank_cnt[i] = '0;
      for (int j = 0; j < WINDOW_SIZE; j++) begin
        ahead = 1'b0;
        if (j != i) begin
          if (mag[j] != mag[i]) begin
            ahead = mag[j] > mag[i];
          end else if (window_r[j] != window_r[i]) begin
            ahead = window_r[j] > window_r[i];
          end else begin
            ahead = (j < i);
          end
        end
        rank_cnt[i] = rank_cnt[i] + RANK_W'(ahead);
      end
    end
  end

  // exactly one sample holds the middle rank
  always_comb begin
    median_nxt = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (rank_cnt[i] == MID_RANK) begin
        median_nxt = median_nxt | window_r[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_st.take) begin
      res_valid_r <= win_st.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_st.take && win_st.valid) begin
      median_r <= median_nxt;
    end
  end

  assign out_valid      = res_st.valid;
  assign out_median_out = median_r;

endmodule

@@ src/mmf9_checker.sv @@
// port-level checks for the magnitude median filter
// depends on mmf9_pkg; bound to magnitude_median_filter_9 below
module mmf9_checker
  import mmf9_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_median_out
);

  // input word holds while waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_sample_in))
    else $error("input word changed while waiting");

  // result word holds while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_median_out))
    else $error("result word changed while stalled");

  // reset empties the result stage
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a free result side never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with result side free");

  // a new result word follows an accepted input word at fixed latency
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, MMF9_LATENCY))
    else $error("result word without matching input word");

endmodule

bind magnitude_median_filter_9 mmf9_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_mmf9_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_sample_in   (in_sample_in),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_median_out (out_median_out)
);
